// ----- rtl/aesc_pkg.sv -----
// ----------------------------------------------------------------------------
// aesc_pkg: AES cipher engine shared types and functions
// Payload structs, register indexes, S-box tables and round transforms.
// ----------------------------------------------------------------------------
package aesc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } ciph_state_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_0    = 3'd1;
  localparam logic [2:0] REG_KEY_1    = 3'd2;
  localparam logic [2:0] REG_KEY_2    = 3'd3;
  localparam logic [2:0] REG_KEY_3    = 3'd4;

  localparam logic       REQ_DECRYPT  = 1'b1;
  localparam logic [7:0] RCON_FIRST   = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int b);
    byte_at = s[127 - 8*b -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c);
      a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2);
      a3 = byte_at(s, 4*c+3);
      t[127 - 32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                             xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    mix_columns = t;
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = byte_at(s, 4*c+r);
        m2[r] = xt(a[r]);
        m4[r] = xt(m2[r]);
        m8[r] = xt(m4[r]);
        m9[r] = m8[r] ^ a[r];
        mb[r] = m8[r] ^ m2[r] ^ a[r];
        md[r] = m8[r] ^ m4[r] ^ a[r];
        me[r] = m8[r] ^ m4[r] ^ m2[r];
      end
      t[127 - 32*c -: 32] = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                             m9[0] ^ me[1] ^ mb[2] ^ md[3],
                             md[0] ^ m9[1] ^ me[2] ^ mb[3],
                             mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    end
    inv_mix_columns = t;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[byte_at(s, r + 4*((c + r) % 4))];
      end
    end
    enc_round = last ? t : mix_columns(t);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_SBOX[byte_at(s, r + 4*c)];
      end
    end
    dec_round = last ? t : inv_mix_columns(t);
  endfunction

endpackage

// ----- rtl/aesc_keysched.sv -----
// ----------------------------------------------------------------------------
// aesc_keysched: round-key expansion and key memories
// Builds one encryption round key per cycle and writes the matching
// equivalent-inverse decryption key at the mirrored address.
// ----------------------------------------------------------------------------
module aesc_keysched #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 mode256,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0]      nr,
  input  logic [255:0]                         key,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0]      raddr,
  output logic                                 busy,
  output logic [127:0]                         enc_q,
  output logic [127:0]                         dec_q
);

  localparam int RW = $clog2(MAX_ROUNDS+1);

  logic [127:0] enc_mem [MAX_ROUNDS+1];
  logic [127:0] dec_mem [MAX_ROUNDS+1];

  logic          busy_r, busy_nxt;
  logic          init_r, init_nxt;
  logic [RW-1:0] j_r, j_nxt;
  logic [7:0]    rcon_r, rcon_nxt;
  logic [127:0]  old_r, old_nxt;
  logic [127:0]  cur_r, cur_nxt;
  logic [127:0]  emit, base, fresh;
  logic [31:0]   tw, w0, w1, w2, w3;
  logic          rot, wr_en;
  logic [RW-1:0] dec_addr;

  assign emit     = mode256 ? old_r : cur_r;
  assign base     = mode256 ? old_r : cur_r;
  assign rot      = !mode256 || !j_r[0];
  assign tw       = rot ? (aesc_pkg::sub_word({cur_r[23:0], cur_r[31:24]}) ^ {rcon_r, 24'h0})
                        : aesc_pkg::sub_word(cur_r[31:0]);
  assign w0       = base[127:96] ^ tw;
  assign w1       = base[95:64] ^ w0;
  assign w2       = base[63:32] ^ w1;
  assign w3       = base[31:0] ^ w2;
  assign fresh    = {w0, w1, w2, w3};
  assign wr_en    = busy_r && !init_r;
  assign dec_addr = nr - j_r;

  always_comb begin
    busy_nxt = busy_r;
    init_nxt = 1'b0;
    j_nxt    = j_r;
    rcon_nxt = rcon_r;
    old_nxt  = old_r;
    cur_nxt  = cur_r;
    if (start) begin
      busy_nxt = 1'b1;
      init_nxt = 1'b1;
    end else if (init_r) begin
      j_nxt    = '0;
      rcon_nxt = aesc_pkg::RCON_FIRST;
      old_nxt  = key[255:128];
      cur_nxt  = mode256 ? key[127:0] : key[255:128];
    end else if (busy_r) begin
      old_nxt = cur_r;
      cur_nxt = fresh;
      if (rot) begin
        rcon_nxt = aesc_pkg::xt(rcon_r);
      end
      j_nxt = j_r + RW'(1);
      if (j_r == nr) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      init_r <= 1'b0;
      j_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      init_r <= init_nxt;
      j_r    <= j_nxt;
    end
    rcon_r <= rcon_nxt;
    old_r  <= old_nxt;
    cur_r  <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      enc_mem[j_r] <= emit;
      dec_mem[dec_addr] <= (j_r == '0 || j_r == nr) ? emit : aesc_pkg::inv_mix_columns(emit);
    end
    enc_q <= enc_mem[raddr];
    dec_q <= dec_mem[raddr];
  end

  assign busy = busy_r;

endmodule

// ----- rtl/aes_block_cipher_128_256.sv -----
// ----------------------------------------------------------------------------
// aes_block_cipher_128_256: AES-128/256 block cipher engine
// Iterative cipher core with one shared round unit and key-schedule memories.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_size_mode (addr 0x00) and key words 0..3 (0x08..0x20) over the
//   64-bit APB port while the engine is idle. Each write restarts the key
//   expansion; in_stall is high meanwhile. A write to a register that does not
//   exist is ignored. Input transfer: in_valid with in_stall low; in_data
//   carries req_type (0 encrypt, 1 decrypt) and the 16-byte block. The shared
//   round unit does one round per cycle; a block goes from input transfer to
//   result through one key whitening step, Nr rounds (Nr = 10 or 14) and one
//   output load. A new input is taken only from the idle state, once the
//   previous block has been loaded into the output register.
//   The result sits in an output register until the output transfer; a new
//   input is taken meanwhile and waits at its end if out_stall stays high.
//   Reset clears the configuration registers and control; round keys are
//   undefined until the first key write.
// ----------------------------------------------------------------------------
module aes_block_cipher_128_256 #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aesc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aesc_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [5:0]          cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int RW = $clog2(MAX_ROUNDS+1);
  localparam logic [RW-1:0] NR128 = RW'(10);
  localparam logic [RW-1:0] NR256 = (MAX_ROUNDS < 14) ? RW'(MAX_ROUNDS) : RW'(14);

  aesc_pkg::ciph_state_t state_r, state_nxt;

  logic          ksm_r;
  logic [63:0]   key_r [4];
  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  logic          ks_start, ks_busy;
  logic [RW-1:0] nr;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic          dec_r;
  logic [127:0]  st_r, st_nxt;
  logic [127:0]  enc_q, dec_q, rk, rnd_out;
  logic          out_valid_r, out_valid_nxt;
  logic [127:0]  res_r;
  logic          in_acc, out_load;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];
  assign ks_start   = cfg_wr && (cfg_idx <= aesc_pkg::REG_KEY_3);
  assign nr         = ksm_r ? NR256 : NR128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksm_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        aesc_pkg::REG_KEY_SIZE: ksm_r <= cfg_pwdata[0];
        aesc_pkg::REG_KEY_0:    key_r[0] <= cfg_pwdata;
        aesc_pkg::REG_KEY_1:    key_r[1] <= cfg_pwdata;
        aesc_pkg::REG_KEY_2:    key_r[2] <= cfg_pwdata;
        aesc_pkg::REG_KEY_3:    key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      aesc_pkg::REG_KEY_SIZE: cfg_prdata = {63'h0, ksm_r};
      aesc_pkg::REG_KEY_0:    cfg_prdata = key_r[0];
      aesc_pkg::REG_KEY_1:    cfg_prdata = key_r[1];
      aesc_pkg::REG_KEY_2:    cfg_prdata = key_r[2];
      aesc_pkg::REG_KEY_3:    cfg_prdata = key_r[3];
      default:                cfg_prdata = '0;
    endcase
  end

  aesc_keysched #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_keysched (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ks_start),
    .mode256 (ksm_r),
    .nr      (nr),
    .key     ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .raddr   (rnd_nxt),
    .busy    (ks_busy),
    .enc_q   (enc_q),
    .dec_q   (dec_q)
  );

  assign in_stall = (state_r != aesc_pkg::ST_IDLE) || ks_busy;
  assign in_acc   = in_valid && !in_stall;
  assign rk       = dec_r ? dec_q : enc_q;
  assign rnd_out  = dec_r ? aesc_pkg::dec_round(st_r, rnd_r == nr)
                          : aesc_pkg::enc_round(st_r, rnd_r == nr);
  assign out_load = (state_r == aesc_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aesc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = aesc_pkg::ST_RUN;
        end
      end
      aesc_pkg::ST_RUN: begin
        if (rnd_r == nr) begin
          state_nxt = aesc_pkg::ST_FIN;
        end
      end
      aesc_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = aesc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aesc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rnd_nxt       = '0;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      aesc_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_nxt = {in_data.block_hi, in_data.block_lo};
        end
      end
      aesc_pkg::ST_RUN: begin
        st_nxt  = ((rnd_r == '0) ? st_r : rnd_out) ^ rk;
        rnd_nxt = (rnd_r == nr) ? '0 : rnd_r + RW'(1);
      end
      aesc_pkg::ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aesc_pkg::ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    st_r <= st_nxt;
    if (in_acc) begin
      dec_r <= (in_data.req_type == aesc_pkg::REQ_DECRYPT);
    end
    if (out_load) begin
      res_r <= st_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.result_hi = res_r[127:64];
  assign out_data.result_lo = res_r[63:0];

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == aesc_pkg::ST_RUN) && (rnd_r == '0))
    else $error("accepted block did not start at round zero");

  a_no_accept_expanding: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> in_stall)
    else $error("input open during key expansion");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aesc_pkg::ST_RUN) |-> (rnd_r <= nr))
    else $error("round counter past last round");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(res_r))
    else $error("stalled result lost");

endmodule
